### hw/rtl/searchable_block_stack_defines.svh
// Assertion macros shared by the searchable block stack RTL.
`ifndef SEARCHABLE_BLOCK_STACK_DEFINES_SVH
`define SEARCHABLE_BLOCK_STACK_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define SBS_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define SBS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/sbs_pkg.sv
// Types and constants shared by the searchable block stack.
`default_nettype none

package sbs_pkg;

    localparam int unsigned ID_W        = 16;
    localparam int unsigned SIZE_W      = 16;
    localparam int unsigned MAX_RESULTS = 16;
    localparam int unsigned DUMP_W      = $clog2(MAX_RESULTS);

    typedef enum logic [1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_SEARCH = 2'd2,
        OP_DUMP   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_EMPTY     = 2'd1,
        STAT_FULL      = 2'd2,
        STAT_NOT_FOUND = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_READ = 2'd1,
        S_EVAL = 2'd2,
        S_OUT  = 2'd3
    } t_state;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [SIZE_W-1:0] size;
    } t_record;

endpackage

`default_nettype wire

### hw/rtl/sbs_store.sv
// Record memory of the stack: one write port and one registered read port.
`default_nettype none

module sbs_store #(
    parameter int unsigned DEPTH = 16,
    localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
    input  wire logic               i_clk,
    input  wire logic               i_wr_en,
    input  wire logic [ADDR_W-1:0]  i_wr_addr,
    input  wire sbs_pkg::t_record   i_wr_data,
    input  wire logic               i_rd_en,
    input  wire logic [ADDR_W-1:0]  i_rd_addr,
    output sbs_pkg::t_record        o_rd_data
);

    sbs_pkg::t_record r_mem [DEPTH];
    sbs_pkg::t_record r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

### hw/rtl/searchable_block_stack.sv
// Top level of the searchable block stack.
`default_nettype none

// A bounded LIFO of (process id, size) records with push, pop, search by id and
// dump from top to bottom. One item is taken at a time; the block is not ready
// again until its last result beat has been taken. A push, or a pop, search or
// dump on an empty stack, shows its result in the cycle after acceptance. A pop
// passes through a read state and an evaluate state before its result shows. A
// search examines records top down, with a read and an evaluate step for each.
// A dump reads and evaluates each record before offering it as a result beat.
// This pacing comes from the single record memory with a registered read
// port and the one id comparator that the sequencer reuses for every record.

`include "searchable_block_stack_defines.svh"

module searchable_block_stack #(
    parameter int unsigned STACK_DEPTH = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [1:0]  i_op,
    input  wire logic [15:0] i_proc_id,
    input  wire logic [15:0] i_size_mb,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [1:0]       o_status,
    output logic [15:0]      o_result_id,
    output logic [15:0]      o_result_size,
    output logic             o_last
);

    localparam int unsigned ADDR_W = $clog2(STACK_DEPTH);
    localparam int unsigned CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(STACK_DEPTH);
    localparam logic [sbs_pkg::DUMP_W-1:0] DUMP_LAST =
        sbs_pkg::DUMP_W'(sbs_pkg::MAX_RESULTS - 1);

    sbs_pkg::t_state  r_state, n_state;
    sbs_pkg::t_op     r_op, n_op;
    sbs_pkg::t_status r_status, n_status;
    logic [sbs_pkg::ID_W-1:0]   r_pid, n_pid;
    logic [sbs_pkg::ID_W-1:0]   r_res_id, n_res_id;
    logic [sbs_pkg::SIZE_W-1:0] r_res_size, n_res_size;
    logic                       r_last, n_last;
    logic [CNT_W-1:0]           r_fill, n_fill;
    logic [ADDR_W-1:0]          r_ptr, n_ptr;
    logic [sbs_pkg::DUMP_W-1:0] r_dump_cnt, n_dump_cnt;

    logic             in_acc;
    logic             out_acc;
    logic             rd_en;
    logic             wr_en;
    logic             full;
    logic             empty;
    logic             hit;
    logic             ptr_zero;
    logic             dump_end;
    logic [CNT_W-1:0] ptr_ext;
    sbs_pkg::t_record wr_data;
    sbs_pkg::t_record rd_data;

    assign in_acc   = i_in_valid & o_in_ready;
    assign out_acc  = o_out_valid & i_out_ready;
    assign full     = (r_fill == FULL_CNT);
    assign empty    = (r_fill == '0);
    assign hit      = (rd_data.id == r_pid);
    assign ptr_zero = (r_ptr == '0);
    assign dump_end = ptr_zero || (r_dump_cnt == DUMP_LAST);
    assign ptr_ext  = CNT_W'(r_ptr);

    assign wr_en        = in_acc && (sbs_pkg::t_op'(i_op) == sbs_pkg::OP_PUSH) && !full;
    assign wr_data.id   = i_proc_id;
    assign wr_data.size = i_size_mb;

    sbs_store #(
        .DEPTH (STACK_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (ADDR_W'(r_fill)),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_ptr),
        .o_rd_data (rd_data)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            sbs_pkg::S_IDLE: begin
                if (in_acc) begin
                    if (sbs_pkg::t_op'(i_op) == sbs_pkg::OP_PUSH || empty) begin
                        n_state = sbs_pkg::S_OUT;
                    end else begin
                        n_state = sbs_pkg::S_READ;
                    end
                end
            end
            sbs_pkg::S_READ: begin
                n_state = sbs_pkg::S_EVAL;
            end
            sbs_pkg::S_EVAL: begin
                if (r_op == sbs_pkg::OP_SEARCH && !hit && !ptr_zero) begin
                    n_state = sbs_pkg::S_READ;
                end else begin
                    n_state = sbs_pkg::S_OUT;
                end
            end
            sbs_pkg::S_OUT: begin
                if (out_acc) begin
                    if (r_op == sbs_pkg::OP_DUMP && !r_last) begin
                        n_state = sbs_pkg::S_READ;
                    end else begin
                        n_state = sbs_pkg::S_IDLE;
                    end
                end
            end
            default: begin
                n_state = sbs_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        rd_en       = 1'b0;
        case (r_state)
            sbs_pkg::S_IDLE: o_in_ready  = 1'b1;
            sbs_pkg::S_READ: rd_en       = 1'b1;
            sbs_pkg::S_OUT:  o_out_valid = 1'b1;
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_op       = r_op;
        n_pid      = r_pid;
        n_status   = r_status;
        n_res_id   = r_res_id;
        n_res_size = r_res_size;
        n_last     = r_last;
        n_fill     = r_fill;
        n_ptr      = r_ptr;
        n_dump_cnt = r_dump_cnt;
        case (r_state)
            sbs_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_op       = sbs_pkg::t_op'(i_op);
                    n_pid      = i_proc_id;
                    n_status   = sbs_pkg::STAT_OK;
                    n_res_id   = '0;
                    n_res_size = '0;
                    n_last     = 1'b1;
                    n_dump_cnt = '0;
                    n_ptr      = ADDR_W'(r_fill - CNT_W'(1));
                    case (sbs_pkg::t_op'(i_op))
                        sbs_pkg::OP_PUSH: begin
                            if (full) begin
                                n_status = sbs_pkg::STAT_FULL;
                            end else begin
                                n_fill     = r_fill + CNT_W'(1);
                                n_res_id   = i_proc_id;
                                n_res_size = i_size_mb;
                            end
                        end
                        sbs_pkg::OP_POP: begin
                            if (empty) begin
                                n_status = sbs_pkg::STAT_EMPTY;
                            end else begin
                                n_fill = r_fill - CNT_W'(1);
                            end
                        end
                        sbs_pkg::OP_SEARCH: begin
                            if (empty) begin
                                n_status = sbs_pkg::STAT_NOT_FOUND;
                            end
                        end
                        default: begin
                            if (empty) begin
                                n_status = sbs_pkg::STAT_EMPTY;
                            end
                        end
                    endcase
                end
            end
            sbs_pkg::S_EVAL: begin
                case (r_op)
                    sbs_pkg::OP_POP: begin
                        n_status   = sbs_pkg::STAT_OK;
                        n_res_id   = rd_data.id;
                        n_res_size = '0;
                        n_last     = 1'b1;
                    end
                    sbs_pkg::OP_SEARCH: begin
                        if (hit) begin
                            n_status   = sbs_pkg::STAT_OK;
                            n_res_id   = rd_data.id;
                            n_res_size = rd_data.size;
                        end else if (ptr_zero) begin
                            n_status   = sbs_pkg::STAT_NOT_FOUND;
                            n_res_id   = '0;
                            n_res_size = '0;
                        end else begin
                            n_ptr = r_ptr - ADDR_W'(1);
                        end
                        n_last = 1'b1;
                    end
                    sbs_pkg::OP_DUMP: begin
                        n_status   = sbs_pkg::STAT_OK;
                        n_res_id   = rd_data.id;
                        n_res_size = rd_data.size;
                        n_last     = dump_end;
                    end
                    default: begin
                        n_last = 1'b1;
                    end
                endcase
            end
            sbs_pkg::S_OUT: begin
                if (out_acc && r_op == sbs_pkg::OP_DUMP && !r_last) begin
                    n_ptr      = r_ptr - ADDR_W'(1);
                    n_dump_cnt = r_dump_cnt + sbs_pkg::DUMP_W'(1);
                end
            end
            default: begin
                n_ptr = r_ptr;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sbs_pkg::S_IDLE;
            r_fill  <= '0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_pid      <= n_pid;
        r_status   <= n_status;
        r_res_id   <= n_res_id;
        r_res_size <= n_res_size;
        r_last     <= n_last;
        r_ptr      <= n_ptr;
        r_dump_cnt <= n_dump_cnt;
    end

    assign o_status      = r_status;
    assign o_result_id   = r_res_id;
    assign o_result_size = r_res_size;
    assign o_last        = r_last;

    // The fill count never passes the stack depth.
    `SBS_ASSERT_SAME(a_fill_bound, i_clk, i_rst_n, 1'b1, r_fill <= FULL_CNT,
        "fill count above stack depth")

    // A push that finds room grows the stack by exactly one record.
    `SBS_ASSERT_NEXT(a_push_grows, i_clk, i_rst_n,
        i_rst_n && in_acc && (i_op == sbs_pkg::OP_PUSH) && !full,
        r_fill == $past(r_fill) + CNT_W'(1), "push did not grow the stack")

    // The stack changes size only when a beat is accepted.
    `SBS_ASSERT_NEXT(a_fill_hold, i_clk, i_rst_n, i_rst_n && !in_acc,
        $stable(r_fill), "fill count changed without an input beat")

    // Every memory read stays at or below the fill count; a pop reads the record it has just taken off.
    `SBS_ASSERT_SAME(a_read_in_range, i_clk, i_rst_n, r_state == sbs_pkg::S_READ,
        ptr_ext <= r_fill, "read beyond the top of the stack")

endmodule

`default_nettype wire

### tb/tb_searchable_block_stack.sv
// Self-checking testbench for the searchable block stack, with its own stack predictor.
`timescale 1ns / 100ps

module tb_searchable_block_stack;
    import sbs_pkg::*;

    localparam int unsigned STACK_DEPTH  = 16;
    localparam int          HOLD_CYCLES  = 150;
    localparam int          DRAIN_CYCLES = 2 * STACK_DEPTH + 8;
    localparam int          MAX_REPORTS  = 10;
    localparam int          RANDOM_ITEMS = 300;

    typedef struct {
        t_status           status;
        logic [ID_W-1:0]   id;
        logic [SIZE_W-1:0] size;
        logic              last;
    } stack_beat_t;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_ready;
    logic [1:0]        i_op;
    logic [15:0]       i_proc_id;
    logic [15:0]       i_size_mb;
    logic              o_out_valid;
    logic              i_out_ready;
    logic [1:0]        o_status;
    logic [15:0]       o_result_id;
    logic [15:0]       o_result_size;
    logic              o_last;

    stack_beat_t       pending_beats[$];
    logic [ID_W-1:0]   stack_ids [STACK_DEPTH];
    logic [SIZE_W-1:0] stack_sizes [STACK_DEPTH];
    int unsigned       stack_fill = 0;
    int unsigned       mismatch_count = 0;
    bit                send_gaps_on = 1'b1;
    bit                recv_stalls_on = 1'b1;
    bit                hold_req = 1'b0;
    int                hold_left = 0;
    int                stall_left = 0;

    searchable_block_stack #(
        .STACK_DEPTH(STACK_DEPTH)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_op         (i_op),
        .i_proc_id    (i_proc_id),
        .i_size_mb    (i_size_mb),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_status     (o_status),
        .o_result_id  (o_result_id),
        .o_result_size(o_result_size),
        .o_last       (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #(10_000_000);
        $display("TB_ERROR");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic void add_beat(t_status st, logic [ID_W-1:0] id,
                                     logic [SIZE_W-1:0] size, logic last);
        stack_beat_t b;
        b.status = st;
        b.id     = id;
        b.size   = size;
        b.last   = last;
        pending_beats.push_back(b);
    endfunction

    // Applies one operation to the predicted stack and queues the beats it produces.
    function automatic void predict_stack_op(t_op op, logic [ID_W-1:0] id,
                                             logic [SIZE_W-1:0] size);
        bit found;
        int n;
        int idx;
        found = 1'b0;
        case (op)
            OP_PUSH: begin
                if (stack_fill >= STACK_DEPTH) begin
                    add_beat(STAT_FULL, '0, '0, 1'b1);
                end else begin
                    stack_ids[stack_fill]   = id;
                    stack_sizes[stack_fill] = size;
                    stack_fill++;
                    add_beat(STAT_OK, id, size, 1'b1);
                end
            end
            OP_POP: begin
                if (stack_fill == 0) begin
                    add_beat(STAT_EMPTY, '0, '0, 1'b1);
                end else begin
                    stack_fill--;
                    add_beat(STAT_OK, stack_ids[stack_fill], '0, 1'b1);
                end
            end
            OP_SEARCH: begin
                for (int i = stack_fill; i > 0 && !found; i--) begin
                    if (stack_ids[i-1] == id) begin
                        add_beat(STAT_OK, stack_ids[i-1], stack_sizes[i-1], 1'b1);
                        found = 1'b1;
                    end
                end
                if (!found) add_beat(STAT_NOT_FOUND, '0, '0, 1'b1);
            end
            default: begin
                if (stack_fill == 0) begin
                    add_beat(STAT_EMPTY, '0, '0, 1'b1);
                end else begin
                    n = (stack_fill < MAX_RESULTS) ? stack_fill : MAX_RESULTS;
                    for (int k = 0; k < n; k++) begin
                        idx = stack_fill - 1 - k;
                        add_beat(STAT_OK, stack_ids[idx], stack_sizes[idx], k == n - 1);
                    end
                end
            end
        endcase
    endfunction

    function automatic void flag_mismatch(string what);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) $display("%0t: %s", $time, what);
    endfunction

    // Output beats are compared with the oldest predicted beat.
    always @(posedge i_clk) begin
        stack_beat_t want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_beats.size() == 0) begin
                flag_mismatch($sformatf("unexpected beat: status=%0d id=%h size=%h last=%b",
                                        o_status, o_result_id, o_result_size, o_last));
            end else begin
                want = pending_beats.pop_front();
                if (o_status !== want.status || o_result_id !== want.id ||
                    o_result_size !== want.size || o_last !== want.last) begin
                    flag_mismatch($sformatf({"beat mismatch: expected status=%0d id=%h ",
                                             "size=%h last=%b, got status=%0d id=%h ",
                                             "size=%h last=%b"},
                                            want.status, want.id, want.size, want.last,
                                            o_status, o_result_id, o_result_size, o_last));
                end
            end
        end
    end

    // The receiver stalls at random and holds off for a long stretch on request.
    initial begin
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else if (recv_stalls_on && $urandom_range(0, 3) == 0) begin
                stall_left = pick_gap();
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    task automatic send_op(t_op op, logic [15:0] id, logic [15:0] size);
        int gap;
        gap = send_gaps_on ? pick_gap() : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op       <= op;
        i_proc_id  <= id;
        i_size_mb  <= size;
        do @(posedge i_clk); while (!o_in_ready);
        predict_stack_op(op, id, size);
    endtask

    task automatic test_empty_stack();
        send_op(OP_POP, 16'hFFFF, 16'hFFFF);
        send_op(OP_SEARCH, 16'h0000, 16'h0000);
        send_op(OP_SEARCH, 16'hFFFF, 16'h0000);
        send_op(OP_DUMP, 16'h5555, 16'hAAAA);
    endtask

    task automatic test_push_search_extremes();
        send_op(OP_PUSH, 16'h0000, 16'h0000);
        send_op(OP_PUSH, 16'hFFFF, 16'hFFFF);
        send_op(OP_SEARCH, 16'h0000, 16'hFFFF);
        send_op(OP_SEARCH, 16'hFFFF, 16'h0000);
        send_op(OP_SEARCH, 16'h1234, 16'h0000);
        send_op(OP_DUMP, 16'h0000, 16'h0000);
    endtask

    // The topmost of two records with the same id must win the search.
    task automatic test_fill_to_full();
        for (int i = 0; i < STACK_DEPTH - 2; i++) begin
            send_op(OP_PUSH, (i == STACK_DEPTH - 3) ? 16'h0000 : 16'(16'h1000 + i),
                    16'(16'h0100 + i));
        end
        send_op(OP_PUSH, 16'hBEEF, 16'hCAFE);
        send_op(OP_SEARCH, 16'h0000, 16'h0000);
        send_op(OP_DUMP, 16'hFFFF, 16'hFFFF);
    endtask

    task automatic test_output_backpressure();
        hold_req = 1'b1;
        send_op(OP_DUMP, 16'h0000, 16'h0000);
        send_op(OP_POP, 16'h0000, 16'h0000);
        send_op(OP_POP, 16'h0000, 16'h0000);
        send_op(OP_PUSH, 16'h7777, 16'h8888);
    endtask

    // Alternates growing and shrinking runs so the stack swings between empty and full.
    task automatic test_random_mix(int count);
        bit          grow;
        int          r;
        t_op         op;
        logic [15:0] id;
        logic [15:0] size;
        grow = 1'b1;
        for (int k = 0; k < count; k++) begin
            if (k % 40 == 0) grow = !grow;
            if (k % 50 == 0) begin
                send_gaps_on   = ($urandom_range(0, 3) != 0);
                recv_stalls_on = send_gaps_on;
            end
            r    = $urandom_range(0, 99);
            id   = 16'($urandom_range(0, 16'hFFFF));
            size = 16'($urandom_range(0, 16'hFFFF));
            if (r < 10) begin
                op = t_op'($urandom_range(0, 3));
            end else begin
                r = $urandom_range(0, 99);
                if (grow) op = (r < 55) ? OP_PUSH : (r < 70) ? OP_POP :
                               (r < 90) ? OP_SEARCH : OP_DUMP;
                else      op = (r < 20) ? OP_PUSH : (r < 60) ? OP_POP :
                               (r < 88) ? OP_SEARCH : OP_DUMP;
                if (op == OP_PUSH && $urandom_range(0, 1) == 0)
                    id = 16'($urandom_range(0, 7));
                if (op == OP_SEARCH && stack_fill > 0 && $urandom_range(0, 9) < 7)
                    id = stack_ids[$urandom_range(0, stack_fill - 1)];
            end
            send_op(op, id, size);
        end
    endtask

    initial begin
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_op       <= OP_PUSH;
        i_proc_id  <= '0;
        i_size_mb  <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_stack();
        test_push_search_extremes();
        test_fill_to_full();
        test_output_backpressure();
        test_random_mix(RANDOM_ITEMS);

        i_in_valid <= 1'b0;
        while (pending_beats.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_beats.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
